// ===== hdl/cobs_start_delimited_deframer_top_assert.svh =====
// Assertion macros for the COBS deframer.
// Included by the top level; no other dependencies.
`ifndef COBS_START_DELIMITED_DEFRAMER_TOP_ASSERT_SVH
`define COBS_START_DELIMITED_DEFRAMER_TOP_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication under reset
`define CSD_ASSERT_NOW(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("deframer check failed");
// Next-cycle implication under reset
`define CSD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("deframer check failed");
`else
`define CSD_ASSERT_NOW(label, clk, rstn, ante, cons)
`define CSD_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

// ===== hdl/csd_pkg.sv =====
// Types, constants and the per-byte decode functions of the COBS deframer.
// No dependencies; used by the result interface and the top level.
package csd_pkg;

  localparam int unsigned CNT_W = 17;
  localparam logic [CNT_W-1:0] COUNT_MAX    = 17'd65538;
  localparam logic [CNT_W-1:0] HEADER_BYTES = 17'd3;
  localparam logic [7:0]       CODE_FULL    = 8'hFF;
  localparam logic [7:0]       CODE_EMPTY   = 8'h01;
  localparam logic [7:0]       DELIM        = 8'h00;

  typedef enum logic [1:0] {
    KIND_DATA      = 2'd0,
    KIND_DONE      = 2'd1,
    KIND_BAD_MAGIC = 2'd2,
    KIND_ABORT     = 2'd3
  } kind_e;

  typedef struct packed {
    logic [7:0]       group_left;
    logic             code_max;
    logic             skipping;
    logic [CNT_W-1:0] count;
    logic [7:0]       header_first;
    logic [7:0]       length_low;
    logic             header_good;
    logic [15:0]      length_value;
  } st_t;

  localparam st_t ST_RESET = '{
    group_left:   8'd0,
    code_max:     1'b1,
    skipping:     1'b0,
    count:        17'd0,
    header_first: 8'd0,
    length_low:   8'd0,
    header_good:  1'b0,
    length_value: 16'd0
  };

  typedef struct packed {
    kind_e            kind;
    logic [7:0]       data_byte;
    logic [CNT_W-1:0] byte_index;
    logic [3:0]       command_code;
    logic [15:0]      payload_length;
    logic             last;
  } res_t;

  typedef struct packed {
    st_t  st;
    res_t dat;
    logic has_rep;
    res_t rep;
  } emit_t;

  typedef struct packed {
    st_t        st;
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
    res_t       r2;
  } step_t;

  function automatic res_t csd_mk(kind_e k, logic [7:0] d, logic [CNT_W-1:0] idx,
                                  logic [3:0] cmd, logic [15:0] len);
    res_t r;
    r.kind           = k;
    r.data_byte      = d;
    r.byte_index     = idx;
    r.command_code   = cmd;
    r.payload_length = len;
    r.last           = 1'b0;
    return r;
  endfunction

  // Report one decoded byte, then run the header and payload-length checks on it
  function automatic emit_t csd_emit(st_t s, logic [7:0] b, logic [3:0] magic);
    emit_t            e;
    logic [CNT_W-1:0] cnt;
    logic             bad;
    e.st      = s;
    e.dat     = csd_mk(KIND_DATA, b, s.count, 4'd0, 16'd0);
    e.has_rep = 1'b0;
    e.rep     = csd_mk(KIND_DATA, 8'd0, '0, 4'd0, 16'd0);
    bad       = 1'b0;
    cnt       = (s.count < COUNT_MAX) ? s.count + CNT_W'(1) : s.count;
    e.st.count = cnt;
    if (cnt == CNT_W'(1)) begin
      e.st.header_first = b;
    end else if (cnt == CNT_W'(2)) begin
      e.st.length_low = b;
    end else if (cnt == HEADER_BYTES) begin
      e.st.length_value = {b, s.length_low};
      if (s.header_first[7:4] == magic) begin
        e.st.header_good = 1'b1;
      end else begin
        bad               = 1'b1;
        e.st.header_good  = 1'b0;
        e.st.skipping     = 1'b1;
        e.has_rep         = 1'b1;
        e.rep = csd_mk(KIND_BAD_MAGIC, 8'd0, cnt, s.header_first[3:0],
                       {b, s.length_low});
      end
    end
    // Completion once the payload reaches the header length
    if (!bad && e.st.header_good && cnt >= HEADER_BYTES &&
        (cnt - HEADER_BYTES) >= {1'b0, e.st.length_value}) begin
      e.st.skipping = 1'b1;
      e.has_rep     = 1'b1;
      e.rep = csd_mk(KIND_DONE, 8'd0, cnt, e.st.header_first[3:0],
                     e.st.length_value);
    end
    return e;
  endfunction

  // Decode one received word into up to three results and the next state
  function automatic step_t csd_step(st_t s, logic [7:0] b, logic [3:0] magic);
    step_t o;
    emit_t e1;
    emit_t e2;
    o.st = s;
    o.n  = 2'd0;
    o.r0 = csd_mk(KIND_DATA, 8'd0, '0, 4'd0, 16'd0);
    o.r1 = o.r0;
    o.r2 = o.r0;
    e1   = '0;
    e2   = '0;
    if (b == DELIM) begin
      if (!s.skipping && s.group_left != 8'd0) begin
        o.r0 = csd_mk(KIND_ABORT, 8'd0, s.count, 4'd0, 16'd0);
        o.n  = 2'd1;
      end
      o.st = ST_RESET;
    end else if (s.skipping) begin
      o.st = s;
    end else if (s.group_left == 8'd0) begin
      // Code word: open a group; a code of one also emits the zero it stands for
      o.st.code_max   = (b == CODE_FULL);
      o.st.group_left = b - 8'd1;
      if (b == CODE_EMPTY) begin
        e1   = csd_emit(o.st, DELIM, magic);
        o.st = e1.st;
        o.r0 = e1.dat;
        o.r1 = e1.rep;
        o.n  = e1.has_rep ? 2'd2 : 2'd1;
      end
    end else begin
      // Data word inside a group
      o.st.group_left = s.group_left - 8'd1;
      e1   = csd_emit(o.st, b, magic);
      o.st = e1.st;
      o.r0 = e1.dat;
      if (e1.has_rep) begin
        o.r1 = e1.rep;
        o.n  = 2'd2;
      end else if (o.st.group_left == 8'd0 && !o.st.code_max) begin
        e2   = csd_emit(e1.st, DELIM, magic);
        o.st = e2.st;
        o.r1 = e2.dat;
        o.r2 = e2.rep;
        o.n  = e2.has_rep ? 2'd3 : 2'd2;
      end else begin
        o.n = 2'd1;
      end
    end
    // Flag the final result of this word
    unique case (o.n)
      2'd1:    o.r0.last = 1'b1;
      2'd2:    o.r1.last = 1'b1;
      2'd3:    o.r2.last = 1'b1;
      default: o.r0.last = 1'b0;
    endcase
    return o;
  endfunction

endpackage

// ===== hdl/csd_rx_if.sv =====
// Input channel of the COBS deframer: one received encoded word.
// Depends on nothing.
interface csd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== hdl/csd_res_if.sv =====
// Result channel of the COBS deframer: one decoded word or report.
// Depends on csd_pkg for the index width.
interface csd_res_if import csd_pkg::*; ;
  logic             valid;
  logic             ready;
  logic [1:0]       kind;
  logic [7:0]       data_byte;
  logic [CNT_W-1:0] byte_index;
  logic [3:0]       command_code;
  logic [15:0]      payload_length;
  logic             last;

  modport source (output valid, output kind, output data_byte, output byte_index,
                  output command_code, output payload_length, output last,
                  input ready);
  modport sink   (input valid, input kind, input data_byte, input byte_index,
                  input command_code, input payload_length, input last,
                  output ready);
endinterface

// ===== hdl/cobs_start_delimited_deframer_top.sv =====
// COBS deframer top level: input register, decode logic, result shift register.
// Depends on csd_pkg, csd_rx_if, csd_res_if and the assertion macro header.
// An accepted input word passes the input register, then the result shift register, to res_o.
// Throughput: 1 input word per cycle while each word yields at most one result and res_o
//   is ready; a word yielding more results (up to 3) holds the input until the last of them
//   is being taken, as the single result port drains the three-entry result shift register.
// Reset: asynchronous, active low; clears decode state, magic nibble and both
//   valid flags at once, no clearing pass.
`include "cobs_start_delimited_deframer_top_assert.svh"

module cobs_start_delimited_deframer_top import csd_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [3:0]   cfg_wdata_i,
  csd_rx_if.sink       rx_i,
  csd_res_if.source    res_o
);

  logic       in_valid_q, in_valid_d;
  logic [7:0] byte_q;
  logic [3:0] magic_q;
  st_t        st_q, st_d;
  res_t       res_q [3];
  res_t       res_d [3];
  logic [1:0] left_q, left_d;
  logic       pop;
  logic       load;
  step_t      step;

  // Decode the held word against the current state
  always_comb begin
    step = csd_step(st_q, byte_q, magic_q);
  end

  assign pop        = (left_q != 2'd0) && res_o.ready;
  assign load       = in_valid_q && ((left_q == 2'd0) || ((left_q == 2'd1) && pop));
  assign rx_i.ready = !in_valid_q || load;

  // Hold or advance the input register
  always_comb begin
    in_valid_d = in_valid_q;
    if (rx_i.valid && rx_i.ready) begin
      in_valid_d = 1'b1;
    end else if (load) begin
      in_valid_d = 1'b0;
    end
  end

  // Load the results of a word, or shift out the one just taken
  always_comb begin
    res_d  = res_q;
    left_d = left_q;
    st_d   = st_q;
    if (load) begin
      res_d[0] = step.r0;
      res_d[1] = step.r1;
      res_d[2] = step.r2;
      left_d   = step.n;
      st_d     = step.st;
    end else if (pop) begin
      res_d[0] = res_q[1];
      res_d[1] = res_q[2];
      left_d   = left_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      left_q     <= 2'd0;
      st_q       <= ST_RESET;
      magic_q    <= 4'd0;
    end else begin
      in_valid_q <= in_valid_d;
      left_q     <= left_d;
      st_q       <= st_d;
      if (cfg_we_i) begin
        magic_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers: no reset
  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      byte_q <= rx_i.rx_byte;
    end
    res_q <= res_d;
  end

  // Drive the result port from the head of the shift register
  assign res_o.valid          = (left_q != 2'd0);
  assign res_o.kind           = res_q[0].kind;
  assign res_o.data_byte      = res_q[0].data_byte;
  assign res_o.byte_index     = res_q[0].byte_index;
  assign res_o.command_code   = res_q[0].command_code;
  assign res_o.payload_length = res_q[0].payload_length;
  assign res_o.last           = res_q[0].last;

  `CSD_ASSERT_NOW(a_last_on_final, clk_i, rst_ni, left_q == 2'd1, res_q[0].last)
  `CSD_ASSERT_NOW(a_no_early_last, clk_i, rst_ni, left_q > 2'd1, !res_q[0].last)
  `CSD_ASSERT_NEXT(a_delim_clears, clk_i, rst_ni, load && byte_q == DELIM, st_q.count == '0 && !st_q.skipping)
  `CSD_ASSERT_NOW(a_count_sat, clk_i, rst_ni, 1'b1, st_q.count <= COUNT_MAX)

endmodule

// ===== bench/tb_cobs_start_delimited_deframer_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the start-delimited COBS deframer: directed and random packets,
// predicted word by word and checked against the result channel.
// Depends on csd_pkg, csd_rx_if, csd_res_if and cobs_start_delimited_deframer_top.
module tb_cobs_start_delimited_deframer_top;
  import csd_pkg::*;

  typedef logic [7:0] word_q_t[$];

  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned PHASE_WORDS    = 70;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic [3:0] cfg_wdata_i = 4'd0;

  csd_rx_if  rx_if ();
  csd_res_if res_if ();

  cobs_start_delimited_deframer_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rx_i        (rx_if),
    .res_o       (res_if)
  );

  // Deframer state as predicted by the bench
  logic [3:0]  magic_cfg;
  logic [7:0]  grp_left;
  logic        grp_full;
  logic        skip_rest;
  logic [16:0] n_decoded;
  logic [7:0]  hdr_first;
  logic [7:0]  len_lo;
  logic        hdr_ok;
  logic [15:0] pay_len;

  res_t        expected_q[$];
  res_t        word_res[$];
  int unsigned useful_words = 0;
  int unsigned errors       = 0;
  int unsigned quiet_cycles = 0;
  bit          idle_on      = 1'b1;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic int unsigned draw_wait();
    return idle_on ? $urandom_range(0, 5) : 0;
  endfunction

  function automatic res_t make_res(kind_e k, logic [7:0] d, logic [16:0] idx,
                                    logic [3:0] cmd, logic [15:0] len);
    res_t r;
    r.kind           = k;
    r.data_byte      = d;
    r.byte_index     = idx;
    r.command_code   = cmd;
    r.payload_length = len;
    r.last           = 1'b0;
    return r;
  endfunction

  // Forget the current packet; the magic nibble survives
  task automatic clear_frame();
    grp_left  = 8'd0;
    grp_full  = 1'b1;
    skip_rest = 1'b0;
    n_decoded = '0;
    hdr_first = 8'd0;
    len_lo    = 8'd0;
    hdr_ok    = 1'b0;
    pay_len   = 16'd0;
  endtask

  // Report one unstuffed byte, then check the header and the payload length
  task automatic push_decoded(input logic [7:0] b);
    word_res.push_back(make_res(KIND_DATA, b, n_decoded, 4'd0, 16'd0));
    if (n_decoded < COUNT_MAX) n_decoded++;
    if (n_decoded == 17'd1) begin
      hdr_first = b;
    end else if (n_decoded == 17'd2) begin
      len_lo = b;
    end else if (n_decoded == HEADER_BYTES) begin
      pay_len = {b, len_lo};
      hdr_ok  = (hdr_first[7:4] == magic_cfg);
      if (!hdr_ok) begin
        skip_rest = 1'b1;
        word_res.push_back(make_res(KIND_BAD_MAGIC, 8'd0, n_decoded, hdr_first[3:0],
                                    pay_len));
        return;
      end
    end
    if (hdr_ok && n_decoded >= HEADER_BYTES &&
        (n_decoded - HEADER_BYTES) >= {1'b0, pay_len}) begin
      skip_rest = 1'b1;
      word_res.push_back(make_res(KIND_DONE, 8'd0, n_decoded, hdr_first[3:0], pay_len));
    end
  endtask

  // Work out the results of one accepted word and queue them
  task automatic predict_word(input logic [7:0] b);
    word_res.delete();
    if (b != DELIM && skip_rest) return;
    useful_words++;
    if (b == DELIM) begin
      if (!skip_rest && grp_left != 8'd0)
        word_res.push_back(make_res(KIND_ABORT, 8'd0, n_decoded, 4'd0, 16'd0));
      clear_frame();
    end else if (grp_left == 8'd0) begin
      grp_full = (b == CODE_FULL);
      grp_left = b - 8'd1;
      if (grp_left == 8'd0 && !grp_full) push_decoded(DELIM);
    end else begin
      grp_left--;
      push_decoded(b);
      if (!skip_rest && grp_left == 8'd0 && !grp_full) push_decoded(DELIM);
    end
    if (word_res.size() > 0) word_res[$].last = 1'b1;
    foreach (word_res[i]) expected_q.push_back(word_res[i]);
  endtask

  // Offer one word after a random gap and hold it until taken
  task automatic send_word(input logic [7:0] w);
    int unsigned gap;
    gap = draw_wait();
    @(negedge clk_i);
    if (gap > 0) begin
      rx_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= w;
    @(posedge clk_i);
    while (!rx_if.ready) @(posedge clk_i);
    predict_word(w);
  endtask

  task automatic send_words(input word_q_t ws);
    foreach (ws[i]) send_word(ws[i]);
  endtask

  // Stop sending and let every expected result come out
  task automatic pause_until_drained();
    @(negedge clk_i);
    rx_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_magic(input logic [3:0] v);
    pause_until_drained();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    magic_cfg    = v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Stuff a decoded message; the final group owes a trailing zero
  function automatic word_q_t cobs_encode(input word_q_t msg);
    word_q_t enc;
    word_q_t grp;
    foreach (msg[i]) begin
      if (msg[i] == 8'h00) begin
        enc.push_back(8'(grp.size() + 1));
        enc = {enc, grp};
        grp.delete();
      end else begin
        grp.push_back(msg[i]);
        if (grp.size() == 254) begin
          enc.push_back(CODE_FULL);
          enc = {enc, grp};
          grp.delete();
        end
      end
    end
    enc.push_back(8'(grp.size() + 1));
    enc = {enc, grp};
    return enc;
  endfunction

  // Header (magic and command, little-endian length) followed by a random body
  function automatic word_q_t make_message(input logic [3:0] nib, input logic [15:0] len,
                                           input int unsigned body);
    word_q_t msg;
    msg.push_back({nib, 4'($urandom_range(0, 15))});
    msg.push_back(len[7:0]);
    msg.push_back(len[15:8]);
    repeat (body)
      msg.push_back(($urandom_range(0, 5) == 0) ? 8'h00 : 8'($urandom_range(1, 255)));
    return msg;
  endfunction

  // Check every accepted result against the oldest expectation
  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (expected_q.size() == 0) begin
        $error("kind: expected nothing, got %0d", res_if.kind);
        errors++;
      end else begin
        want = expected_q.pop_front();
        check_field("kind", want.kind, res_if.kind);
        check_field("data_byte", want.data_byte, res_if.data_byte);
        check_field("byte_index", want.byte_index, res_if.byte_index);
        check_field("command_code", want.command_code, res_if.command_code);
        check_field("payload_length", want.payload_length, res_if.payload_length);
        check_field("last", want.last, res_if.last);
      end
    end
  end

  // Stall the result channel for a random gap before each result is taken
  initial begin
    int unsigned stall;
    res_if.ready = 1'b0;
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        @(negedge clk_i);
        res_if.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      res_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!(res_if.valid && res_if.ready)) @(posedge clk_i);
    end
  end

  // End the run if no word moves on either channel for too long
  always @(posedge clk_i) begin
    if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Bytes ahead of the first delimiter form a packet of their own
  task automatic test_leading_bytes();
    send_words('{8'h03, 8'h0A, 8'h05});
  endtask

  // Delimiter inside an open group aborts; a second one says nothing
  task automatic test_abort_and_stray_delimiters();
    send_words('{DELIM, 8'h05, 8'h11, 8'h22, DELIM, DELIM});
  endtask

  // Zero payload length completes on the third decoded byte
  task automatic test_zero_length_header();
    send_words('{8'h02, 8'h03, 8'h01, 8'h01, 8'h07});
  endtask

  // Reports on a group-ending byte drop the owed zero; skipped bytes stay silent
  task automatic test_reports_on_group_end();
    send_words('{DELIM, 8'h04, 8'hF5, 8'h06, 8'h07});
    send_words('{DELIM, 8'h03, 8'h05, 8'h02, 8'h03, 8'hAA, 8'hFF});
    send_words('{DELIM, 8'h06, 8'hF1, 8'h34, 8'h12, 8'hFF, DELIM});
  endtask

  // Mostly well-formed packets, with bad headers, short payloads, cuts and noise
  task automatic run_random_packets(input int unsigned words);
    int unsigned target;
    int unsigned pick;
    int unsigned body;
    int unsigned cut;
    logic [3:0]  nib;
    logic [15:0] len;
    word_q_t     enc;
    target = useful_words + words;
    while (useful_words < target) begin
      idle_on = ($urandom_range(0, 4) != 0);
      pick = $urandom_range(0, 9);
      body = ($urandom_range(0, 24) == 0) ? $urandom_range(200, 300) : $urandom_range(0, 14);
      nib  = magic_cfg;
      len  = 16'(body);
      case (pick)
        0: nib = magic_cfg ^ 4'($urandom_range(1, 15));
        1: len = 16'(body + $urandom_range(1, 4));
        2: len = 16'($urandom_range(0, 65535));
        default: ;
      endcase
      enc = cobs_encode(make_message(nib, len, body + $urandom_range(0, 3)));
      cut = (pick == 3) ? $urandom_range(1, enc.size()) : enc.size();
      if (pick == 4) begin
        // raw noise, zeros included
        repeat ($urandom_range(1, 12)) send_word(8'($urandom_range(0, 255)));
      end else begin
        send_word(DELIM);
        for (int unsigned i = 0; i < cut; i++) send_word(enc[i]);
      end
      if ($urandom_range(0, 15) == 0) pause_until_drained();
    end
    idle_on = 1'b1;
  endtask

  // Walk the magic nibble through its extremes and random values
  task automatic test_magic_sweep();
    set_magic(4'hF);
    run_random_packets(PHASE_WORDS);
    set_magic(4'($urandom_range(1, 14)));
    run_random_packets(PHASE_WORDS);
    set_magic(4'h0);
    run_random_packets(PHASE_WORDS);
    set_magic(4'($urandom_range(0, 15)));
    run_random_packets(PHASE_WORDS);
  endtask

  // Full-length code word: a cut inside its group aborts, a bad header inside it skips
  task automatic test_full_code_group();
    set_magic(4'($urandom_range(0, 15)));
    idle_on = 1'b0;
    send_words('{DELIM, CODE_FULL, {magic_cfg, 4'h6}, 8'h01, 8'h01, 8'h55, DELIM});
    send_words('{DELIM, CODE_FULL, {~magic_cfg, 4'h2}, 8'h09, 8'h01, 8'h77, DELIM});
    idle_on = 1'b1;
  endtask

  initial begin
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = 8'd0;
    magic_cfg     = 4'd0;
    clear_frame();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_leading_bytes();
    test_abort_and_stray_delimiters();
    test_zero_length_header();
    test_reports_on_group_end();
    test_magic_sweep();
    test_full_code_group();

    pause_until_drained();
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
